// ===== hdl/frcs_pkg.sv =====
// shared types and constants of the flash range command splitter
// used by frcs_front, frcs_queue, frcs_back and the top level
`default_nettype none

package frcs_pkg;

  // default device geometry in bytes, each a power of two
  localparam int unsigned PAGE_BYTES_DEF   = 512;
  localparam int unsigned SECTOR_BYTES_DEF = 4096;
  localparam int unsigned BLOCK_BYTES_DEF  = 1 << 16;

  // field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned ADDR_W   = 22;
  localparam int unsigned COUNT_W  = 19;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CAP_W    = 23;

  // stream word widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  // a run stops after this many erase commands
  localparam int unsigned MAX_CMDS  = 63;
  localparam int unsigned CNT_W     = 6;
  // program or write longer than this many pages is refused
  localparam int unsigned PAGES_MAX = 62;

  // request opcodes
  localparam logic [OPCODE_W-1:0] OP_ERASE   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PROGRAM = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd2;

  // device commands
  localparam logic [CMD_W-1:0] CMD_BLOCK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SECTOR     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PAGE_ERASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PROGRAM    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DONE       = 3'd5;

  // status codes carried by done
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd3;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // how the back end has to treat a request
  typedef enum logic [1:0] {
    KIND_ERASE     = 2'd0,
    KIND_PROGRAM   = 2'd1,
    KIND_WRITE     = 2'd2,
    KIND_DONE_ONLY = 2'd3
  } kind_e;

  // classified request handed from front to back
  typedef struct packed {
    kind_e                kind;
    logic [STATUS_W-1:0]  status;
    logic [ADDR_W-1:0]    addr;
    logic [COUNT_W-1:0]   size;
  } desc_t;

endpackage

`default_nettype wire

// ===== hdl/frcs_front.sv =====
// front end: capacity register, request intake and classification
// depends on frcs_pkg
`default_nettype none

module frcs_front #(
  parameter int unsigned PAGE_BYTES = frcs_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // capacity register write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [frcs_pkg::CAP_W-1:0]          cfg_data_i,
  // request stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // start_address [21:0], byte_count [40:22], zero fill above
  input  wire logic [frcs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode [1:0]
  input  wire logic [frcs_pkg::OPCODE_W-1:0]       s_axis_tuser,
  // queue push side
  output logic                                     push_o,
  output frcs_pkg::desc_t                          push_desc_o,
  input  wire logic                                full_i
);

  localparam logic [31:0] TooLongBytes = 32'(frcs_pkg::PAGES_MAX * PAGE_BYTES);

  logic [frcs_pkg::CAP_W-1:0]    cap_q;
  logic [frcs_pkg::ADDR_W-1:0]   addr;
  logic [frcs_pkg::COUNT_W-1:0]  size;
  logic [frcs_pkg::CAP_W-1:0]    end_addr;
  frcs_pkg::desc_t               desc;

  // capacity register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // unpack the request word
  assign addr = s_axis_tdata[frcs_pkg::ADDR_W-1:0];
  assign size = s_axis_tdata[frcs_pkg::ADDR_W +: frcs_pkg::COUNT_W];

  // end of request, never overflows 23 bits
  assign end_addr = frcs_pkg::CAP_W'(addr) + frcs_pkg::CAP_W'(size);

  // classify: range check first, then trivial cases, then length limit
  always_comb begin
    desc.addr   = addr;
    desc.size   = size;
    desc.status = frcs_pkg::ST_OK;
    desc.kind   = frcs_pkg::KIND_DONE_ONLY;
    if (end_addr > cap_q) begin
      desc.status = frcs_pkg::ST_RANGE;
    end else if (size == '0) begin
      desc.status = frcs_pkg::ST_OK;
    end else begin
      unique case (s_axis_tuser) inside
        frcs_pkg::OP_ERASE: begin
          desc.kind = frcs_pkg::KIND_ERASE;
        end
        frcs_pkg::OP_PROGRAM, frcs_pkg::OP_WRITE: begin
          if (32'(size) > TooLongBytes) begin
            desc.status = frcs_pkg::ST_TOO_LONG;
          end else if (s_axis_tuser == frcs_pkg::OP_PROGRAM) begin
            desc.kind = frcs_pkg::KIND_PROGRAM;
          end else begin
            desc.kind = frcs_pkg::KIND_WRITE;
          end
        end
        default: begin
          desc.status = frcs_pkg::ST_OK;
        end
      endcase
    end
  end

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;
  assign push_desc_o   = desc;

endmodule

`default_nettype wire

// ===== hdl/frcs_queue.sv =====
// short descriptor queue between front and back end
// depends on frcs_pkg
`default_nettype none

module frcs_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire frcs_pkg::desc_t  push_desc_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output frcs_pkg::desc_t       pop_desc_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = $clog2(frcs_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(frcs_pkg::QUEUE_DEPTH + 1);

  frcs_pkg::desc_t   mem_q [frcs_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (cnt_q == CntW'(frcs_pkg::QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_desc_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(frcs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(frcs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/frcs_back.sv =====
// back end: command sequencer with registered output word
// depends on frcs_pkg
`default_nettype none

module frcs_back #(
  parameter int unsigned PAGE_BYTES   = frcs_pkg::PAGE_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = frcs_pkg::SECTOR_BYTES_DEF,
  parameter int unsigned BLOCK_BYTES  = frcs_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // queue pop side
  output logic                                  pop_o,
  input  wire frcs_pkg::desc_t                  pop_desc_i,
  input  wire logic                             empty_i,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // address [21:0], length [38:22], status [40:39], zero fill above
  output logic [frcs_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // command [2:0]
  output logic [frcs_pkg::CMD_W-1:0]            m_axis_tuser,
  output logic                                  m_axis_tlast
);

  localparam int unsigned PgLog  = $clog2(PAGE_BYTES);
  localparam int unsigned SecLog = $clog2(SECTOR_BYTES);
  localparam int unsigned BlkLog = $clog2(BLOCK_BYTES);
  // a step is at most one block
  localparam int unsigned StepW  = BlkLog + 1;
  // running address may pass 2^22 before the end of a run
  localparam int unsigned RunW   = frcs_pkg::CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e                          state_q, state_d;
  frcs_pkg::kind_e                 kind_q, kind_d;
  logic [frcs_pkg::STATUS_W-1:0]   stat_q, stat_d;
  logic [RunW-1:0]                 addr_q, addr_d;
  logic [frcs_pkg::COUNT_W-1:0]    size_q, size_d;
  logic [frcs_pkg::CNT_W-1:0]      cnt_q, cnt_d;

  // output word registers
  logic                            ovalid_q, ovalid_d;
  logic [frcs_pkg::CMD_W-1:0]      ocmd_q, ocmd_d;
  logic [frcs_pkg::ADDR_W-1:0]     oaddr_q, oaddr_d;
  logic [frcs_pkg::LEN_W-1:0]      olen_q, olen_d;
  logic [frcs_pkg::STATUS_W-1:0]   ostat_q, ostat_d;
  logic                            olast_q, olast_d;

  logic                            out_free;
  logic                            blk_fit, sec_fit, pg_fit;
  logic [frcs_pkg::COUNT_W-1:0]    room;
  logic [frcs_pkg::COUNT_W-1:0]    chunk;
  logic [StepW-1:0]                step;
  logic [frcs_pkg::CMD_W-1:0]      step_cmd;
  logic                            emit_step;
  logic [frcs_pkg::STATUS_W-1:0]   done_stat;

  assign out_free = !ovalid_q || m_axis_tready;

  // largest aligned erase unit that fits
  assign blk_fit = (addr_q[BlkLog-1:0] == '0) && (32'(size_q) >= 32'(BLOCK_BYTES));
  assign sec_fit = (addr_q[SecLog-1:0] == '0) && (32'(size_q) >= 32'(SECTOR_BYTES));
  assign pg_fit  = (addr_q[PgLog-1:0] == '0)  && (32'(size_q) >= 32'(PAGE_BYTES));

  // bytes left up to the next page boundary
  assign room  = frcs_pkg::COUNT_W'(PAGE_BYTES) - frcs_pkg::COUNT_W'(addr_q[PgLog-1:0]);
  assign chunk = (size_q < room) ? size_q : room;

  // decide the next item of the run
  always_comb begin
    emit_step = 1'b0;
    step      = '0;
    step_cmd  = frcs_pkg::CMD_DONE;
    done_stat = stat_q;
    if (kind_q == frcs_pkg::KIND_DONE_ONLY || size_q == '0) begin
      done_stat = stat_q;
    end else if (kind_q == frcs_pkg::KIND_ERASE) begin
      if (cnt_q == frcs_pkg::CNT_W'(frcs_pkg::MAX_CMDS)) begin
        done_stat = frcs_pkg::ST_TOO_LONG;
      end else if (blk_fit) begin
        emit_step = 1'b1;
        step      = StepW'(BLOCK_BYTES);
        step_cmd  = frcs_pkg::CMD_BLOCK;
      end else if (sec_fit) begin
        emit_step = 1'b1;
        step      = StepW'(SECTOR_BYTES);
        step_cmd  = frcs_pkg::CMD_SECTOR;
      end else if (pg_fit) begin
        emit_step = 1'b1;
        step      = StepW'(PAGE_BYTES);
        step_cmd  = frcs_pkg::CMD_PAGE_ERASE;
      end else begin
        done_stat = frcs_pkg::ST_MISALIGNED;
      end
    end else begin
      emit_step = 1'b1;
      step      = StepW'(chunk);
      step_cmd  = (kind_q == frcs_pkg::KIND_PROGRAM) ? frcs_pkg::CMD_PROGRAM
                                                      : frcs_pkg::CMD_WRITE;
    end
  end

  // sequencer and output register
  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    stat_d   = stat_q;
    addr_d   = addr_q;
    size_d   = size_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    ocmd_d   = ocmd_q;
    oaddr_d  = oaddr_q;
    olen_d   = olen_q;
    ostat_d  = ostat_q;
    olast_d  = olast_q;
    pop_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          kind_d  = pop_desc_i.kind;
          stat_d  = pop_desc_i.status;
          addr_d  = RunW'(pop_desc_i.addr);
          size_d  = pop_desc_i.size;
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          if (emit_step) begin
            ocmd_d  = step_cmd;
            oaddr_d = addr_q[frcs_pkg::ADDR_W-1:0];
            olen_d  = step[frcs_pkg::LEN_W-1:0];
            ostat_d = frcs_pkg::ST_OK;
            olast_d = 1'b0;
            addr_d  = addr_q + RunW'(step);
            size_d  = frcs_pkg::COUNT_W'(32'(size_q) - 32'(step));
            cnt_d   = cnt_q + 1'b1;
          end else begin
            ocmd_d  = frcs_pkg::CMD_DONE;
            oaddr_d = '0;
            olen_d  = '0;
            ostat_d = done_stat;
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // run context and output payload
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    stat_q  <= stat_d;
    addr_q  <= addr_d;
    size_q  <= size_d;
    cnt_q   <= cnt_d;
    ocmd_q  <= ocmd_d;
    oaddr_q <= oaddr_d;
    olen_q  <= olen_d;
    ostat_q <= ostat_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ocmd_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = frcs_pkg::OUT_DATA_W'({ostat_q, olen_q, oaddr_q});

endmodule

`default_nettype wire

// ===== hdl/flash_range_command_splitter.sv =====
// Splits one flash request (erase, program or write) into device commands followed
// by a done word carrying the status. The front end checks the request against the
// capacity register and classifies it in the accept cycle, then parks it in a
// two-entry queue, so up to two requests are taken while a run is still going out.
// The back end sequencer loads a request while idle and then emits one word per
// cycle while the output register is free; a run is at most 64 words. Erases use
// the largest aligned block, sector or page unit; program and write are cut at
// page boundaries. Page, sector and block sizes must be powers of two. There is
// no clearing pass after reset.
// depends on frcs_pkg, frcs_front, frcs_queue, frcs_back
`default_nettype none

module flash_range_command_splitter #(
  parameter int unsigned PAGE_BYTES   = frcs_pkg::PAGE_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = frcs_pkg::SECTOR_BYTES_DEF,
  parameter int unsigned BLOCK_BYTES  = frcs_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // capacity_bytes write channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [frcs_pkg::CAP_W-1:0]       cfg_data_i,
  // request stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // start_address [21:0], byte_count [40:22], zero fill above
  input  wire logic [frcs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // opcode [1:0]
  input  wire logic [frcs_pkg::OPCODE_W-1:0]    s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // address [21:0], length [38:22], status [40:39], zero fill above
  output logic [frcs_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // command [2:0]
  output logic [frcs_pkg::CMD_W-1:0]            m_axis_tuser,
  output logic                                  m_axis_tlast
);

  logic             push;
  frcs_pkg::desc_t  push_desc;
  logic             full;
  logic             pop;
  frcs_pkg::desc_t  pop_desc;
  logic             empty;

  // intake and classification
  frcs_front #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .push_desc_o   (push_desc),
    .full_i        (full)
  );

  // request queue
  frcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .pop_desc_o  (pop_desc),
    .empty_o     (empty)
  );

  // command sequencer
  frcs_back #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .BLOCK_BYTES  (BLOCK_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_o         (pop),
    .pop_desc_i    (pop_desc),
    .empty_i       (empty),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
